### rtl/core/icv_pkg.sv
// types and constants shared by the check tag pipeline
`timescale 1ns / 1ps

package icv_pkg;

    localparam logic [63:0] W_SALT0 = 64'hbaddecafbaddecaf;
    localparam logic [63:0] W_SALT1 = 64'h0123456789abcdef;
    localparam logic [63:0] W_SALT2 = 64'hdeadbeefdeadbeef;
    localparam logic [31:0] N_SALT0 = 32'hbaddecaf;
    localparam logic [31:0] N_SALT1 = 32'h01234567;
    localparam logic [31:0] N_SALT2 = 32'hdeadbeef;
    localparam logic [31:0] N_MUL   = 32'h27d4eb2d;
    localparam logic [31:0] N_XOR   = 32'd61;

    // group bit positions of the replaced parity bits
    localparam logic [3:0] W_POS_A = 4'd11;
    localparam logic [3:0] W_POS_B = 4'd12;
    localparam logic [3:0] N_POS_A = 4'd0;
    localparam logic [3:0] N_POS_B = 4'd15;

    localparam logic KIND_GEN = 1'b0;
    localparam logic KIND_VAL = 1'b1;

    localparam int unsigned IN_DATA_W  = 88;
    localparam int unsigned OUT_DATA_W = 88;

    typedef struct packed {
        logic        kind;
        logic        wide;
        logic [63:0] ident;
        logic        strength;
        logic [15:0] tag_in;
    } t_item;

endpackage

### rtl/core/id_check_tag_generate_validate_top.sv
// Check tag generator and validator. Each input word asks to generate or to
// validate a 16-bit check tag for a 64-bit or 32-bit identifier. The block
// takes one word per clock while the output is not stalled; each result passes
// four hash stages (the second one holds a single 32x32 constant multiplier)
// and a registered tag and check stage that drives the output.
// Every stage holds its word while the output waits, so a stall loses nothing
// and bubbles close up as words move on.
`timescale 1ns / 1ps

module id_check_tag_generate_validate_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // ident[63:0], strength[64], tag_in[80:65], zero pad[87:81]
    input  logic [icv_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // kind[0], wide[1]
    input  logic [1:0]                      i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // tag_out[15:0], ok[16], ident_out[80:17], zero pad[87:81]
    output logic [icv_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import icv_pkg::*;

    t_item       w_in_item;
    t_item       w_h_item;
    logic        w_h_valid;
    logic        w_h_ready;
    logic [15:0] w_hash;

    logic        r_out_vld;
    logic [15:0] r_tag;
    logic        r_ok;
    logic [63:0] r_ident;
    logic [15:0] n_tag;
    logic        n_ok;
    logic [63:0] n_ident;

    assign w_in_item.kind     = i_s_tuser[0];
    assign w_in_item.wide     = i_s_tuser[1];
    assign w_in_item.ident    = i_s_tdata[63:0];
    assign w_in_item.strength = i_s_tdata[64];
    assign w_in_item.tag_in   = i_s_tdata[80:65];

    icv_hash_pipe u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_item  (w_in_item),
        .o_valid (w_h_valid),
        .i_ready (w_h_ready),
        .o_item  (w_h_item),
        .o_hash  (w_hash)
    );

    assign w_h_ready = !r_out_vld || i_m_tready;

    // tag insertion or check against the recomputed hash
    always_comb begin
        logic [3:0]  pos_a, pos_b;
        logic        base, bias, pa, pb, pass;
        logic [15:0] t, keep, one_a, one_b;
        pos_a = w_h_item.wide ? W_POS_A : N_POS_A;
        pos_b = w_h_item.wide ? W_POS_B : N_POS_B;
        one_a = 16'd1 << pos_a;
        one_b = 16'd1 << pos_b;
        base  = w_h_item.wide;
        bias  = w_h_item.strength ? base : !base;
        keep  = ~(one_a | one_b);
        t     = (w_h_item.kind == KIND_GEN) ? w_hash : w_h_item.tag_in;
        pa    = t[pos_a] ^ t[3] ^ t[7] ^ t[10];
        pb    = t[pos_b] ^ t[4] ^ t[13] ^ t[1];
        pass  = (pa == pb) && (((w_hash ^ w_h_item.tag_in) & keep) == 16'd0);
        n_tag   = 16'd0;
        n_ok    = 1'b1;
        n_ident = w_h_item.ident;
        case (w_h_item.kind)
            KIND_GEN: begin
                n_tag = w_hash ^ ({16{pa ^ bias}} & one_a) ^ ({16{pb ^ bias}} & one_b);
            end
            KIND_VAL: begin
                n_ok = pass;
                if (pass) begin
                    n_ident = {w_h_item.ident[62:0], pa ^ base ^ 1'b1};
                    if (!w_h_item.wide) begin
                        n_ident[63:32] = 32'd0;
                    end
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_h_ready) begin
            r_out_vld <= w_h_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_h_ready) begin
            r_tag   <= n_tag;
            r_ok    <= n_ok;
            r_ident <= n_ident;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {7'd0, r_ident, r_ok, r_tag};

    // input back-pressure can only come from a held output word
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without a held output word");

    // the hash pipe is held only while the output register is full and waiting
    a_pipe_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_h_valid && !w_h_ready) |-> (r_out_vld && !i_m_tready))
        else $error("hash pipe held with output free");

    // a failed check never carries a tag
    a_fail_no_tag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !r_ok) |-> (r_tag == 16'd0))
        else $error("failed check word carries a tag");

    // a word leaving the hash pipe lands in the output register
    a_handoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_h_valid && w_h_ready) |=> o_m_tvalid)
        else $error("hash result lost at output stage");

endmodule

### rtl/core/icv_hash_pipe.sv
// four stage pipelined salted integer hash, folded to 16 bits
`timescale 1ns / 1ps

module icv_hash_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  icv_pkg::t_item i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output icv_pkg::t_item o_item,
    output logic [15:0]   o_hash
);
    import icv_pkg::*;

    logic [3:0]  r_vld;
    logic [3:0]  w_en;
    t_item       r_item1, r_item2, r_item3, r_item4;
    logic [63:0] r_h1, r_h2, r_h3;
    logic [15:0] r_f;

    t_item       n_item0;
    logic [63:0] n_h1, n_h2, n_h3;
    logic [15:0] n_f;

    // stage enables: a stage loads when empty or when the next one moves
    assign w_en[3]  = !r_vld[3] || i_ready;
    assign w_en[2]  = !r_vld[2] || w_en[3];
    assign w_en[1]  = !r_vld[1] || w_en[2];
    assign w_en[0]  = !r_vld[0] || w_en[1];
    assign o_ready  = w_en[0];
    assign o_valid  = r_vld[3];
    assign o_item   = r_item4;
    assign o_hash   = r_f;

    // stage 1: pre-multiply rounds
    always_comb begin
        logic [63:0] v, w0, w1;
        logic [31:0] n, m0, m1, m2;
        n_item0 = i_item;
        if (!i_item.wide) begin
            n_item0.ident = {32'd0, i_item.ident[31:0]};
        end
        v  = n_item0.ident;
        w0 = ~v + (v << 18) - W_SALT0;
        w1 = w0 ^ (w0 >> 31) ^ W_SALT1;
        n  = v[31:0];
        m0 = (n ^ N_XOR) ^ (n >> 16) ^ N_SALT0;
        m1 = m0 + (m0 << 3) - N_SALT1;
        m2 = m1 ^ (m1 >> 4) ^ N_SALT2;
        n_h1 = i_item.wide ? w1 : {32'd0, m2};
    end

    // stage 2: constant multiply
    always_comb begin
        logic [63:0] w;
        logic [31:0] m;
        w = (r_h1 << 4) + (r_h1 << 2) + r_h1;
        m = r_h1[31:0] * N_MUL;
        n_h2 = r_item1.wide ? w : {32'd0, m};
    end

    // stage 3: post-multiply rounds
    always_comb begin
        logic [63:0] a0, a1;
        logic [31:0] b0, b1;
        a0 = r_h2 + W_SALT2;
        a1 = a0 ^ (a0 >> 11) ^ W_SALT0;
        b0 = r_h2[31:0] + N_SALT0;
        b1 = b0 ^ (b0 >> 15);
        n_h3 = r_item2.wide ? (a1 + (a1 << 6)) : {32'd0, b1};
    end

    // stage 4: last round and fold to 16 bits
    always_comb begin
        logic [63:0] c0, c1;
        logic [15:0] f0, f1;
        c0 = r_h3 - W_SALT1;
        c1 = c0 ^ (c0 >> 22);
        f0 = (c1[15:0] + c1[31:16]) ^ c1[47:32];
        f1 = f0 + c1[63:48];
        n_f = r_item3.wide ? f1 : (r_h3[15:0] + r_h3[31:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_item1 <= n_item0;
            r_h1    <= n_h1;
        end
        if (w_en[1]) begin
            r_item2 <= r_item1;
            r_h2    <= n_h2;
        end
        if (w_en[2]) begin
            r_item3 <= r_item2;
            r_h3    <= n_h3;
        end
        if (w_en[3]) begin
            r_item4 <= r_item3;
            r_f     <= n_f;
        end
    end

endmodule

### bench/tb_id_check_tag_generate_validate_top.sv
// self-checking bench for the check tag generator and validator
`timescale 1ns / 1ps

module tb_id_check_tag_generate_validate_top;
    import icv_pkg::*;

    localparam logic [63:0] W_MUL = 64'd21;
    localparam logic [63:0] LOW32_MASK = 64'h0000_0000_ffff_ffff;
    localparam int unsigned RANDOM_WORDS_PER_PHASE = 185;
    localparam int unsigned DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [15:0] tag_out;
        logic        ok;
        logic [63:0] ident_out;
    } t_tag_result;

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata = '0;
    logic [1:0]            i_s_tuser = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;

    t_item       id_words_q[$];
    t_tag_result tag_results_due[$];
    int unsigned words_queued = 0;
    int unsigned words_taken = 0;
    int unsigned mismatches = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    logic        s_taken = 1'b0;

    id_check_tag_generate_validate_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [15:0] hash_wide_id(input logic [63:0] v);
        logic [63:0] h;
        logic [15:0] f;
        h = ~v + (v << 18);
        h = h - W_SALT0;
        h = h ^ (h >> 31);
        h = h ^ W_SALT1;
        h = h * W_MUL;
        h = h + W_SALT2;
        h = h ^ (h >> 11);
        h = h ^ W_SALT0;
        h = h + (h << 6);
        h = h - W_SALT1;
        h = h ^ (h >> 22);
        f = h[15:0] + h[31:16];
        f = f ^ h[47:32];
        f = f + h[63:48];
        return f;
    endfunction

    function automatic logic [15:0] hash_narrow_id(input logic [31:0] v);
        logic [31:0] h;
        logic [15:0] f;
        h = (v ^ N_XOR) ^ (v >> 16);
        h = h ^ N_SALT0;
        h = h + (h << 3);
        h = h - N_SALT1;
        h = h ^ (h >> 4);
        h = h ^ N_SALT2;
        h = h * N_MUL;
        h = h + N_SALT0;
        h = h ^ (h >> 15);
        f = h[15:0] + h[31:16];
        return f;
    endfunction

    function automatic t_tag_result predict_tag_result(input t_item w);
        logic [63:0] id;
        logic [63:0] mask;
        logic [15:0] h;
        logic [15:0] keep;
        logic [3:0]  pos_a;
        logic [3:0]  pos_b;
        logic        base_bias;
        logic        bias;
        logic        pa;
        logic        pb;
        t_tag_result r;
        mask = w.wide ? '1 : LOW32_MASK;
        id = w.ident & mask;
        pos_a = w.wide ? W_POS_A : N_POS_A;
        pos_b = w.wide ? W_POS_B : N_POS_B;
        base_bias = w.wide;
        h = w.wide ? hash_wide_id(id) : hash_narrow_id(id[31:0]);
        if (w.kind == KIND_GEN) begin
            bias = w.strength ? base_bias : ~base_bias;
            pa = h[pos_a] ^ h[3] ^ h[7] ^ h[10] ^ bias;
            pb = h[pos_b] ^ h[4] ^ h[13] ^ h[1] ^ bias;
            h[pos_a] = h[pos_a] ^ pa;
            h[pos_b] = h[pos_b] ^ pb;
            r.tag_out = h;
            r.ok = 1'b1;
            r.ident_out = id;
        end else begin
            pa = w.tag_in[pos_a] ^ w.tag_in[3] ^ w.tag_in[7] ^ w.tag_in[10];
            pb = w.tag_in[pos_b] ^ w.tag_in[4] ^ w.tag_in[13] ^ w.tag_in[1];
            keep = 16'hffff;
            keep[pos_a] = 1'b0;
            keep[pos_b] = 1'b0;
            r.tag_out = '0;
            if (pa == pb && ((h ^ w.tag_in) & keep) == 16'h0) begin
                r.ok = 1'b1;
                r.ident_out = ((id << 1) | {63'b0, pa ^ base_bias ^ 1'b1}) & mask;
            end else begin
                r.ok = 1'b0;
                r.ident_out = id;
            end
        end
        return r;
    endfunction

    function automatic t_item tag_word(input logic kind, input logic wide,
                                       input logic [63:0] ident, input logic strength,
                                       input logic [15:0] tag_in);
        t_item w;
        w.kind = kind;
        w.wide = wide;
        w.ident = ident;
        w.strength = strength;
        w.tag_in = tag_in;
        return w;
    endfunction

    // validate word carrying the tag that generation gives, with the bits in flip flipped
    function automatic t_item check_word(input logic wide, input logic [63:0] ident,
                                         input logic strength, input logic [15:0] flip);
        t_tag_result g;
        g = predict_tag_result(tag_word(KIND_GEN, wide, ident, strength, 16'h0));
        return tag_word(KIND_VAL, wide, ident, ~strength, g.tag_out ^ flip);
    endfunction

    function automatic t_item random_word();
        t_item       w;
        int unsigned pick;
        logic [63:0] id;
        logic        wide;
        logic        strength_bit;
        wide = 1'($urandom_range(1));
        strength_bit = 1'($urandom_range(1));
        id = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (pick < 5)
            id = id & 64'hff;
        else if (pick < 10)
            id = id | 64'h8000_0000_8000_0000;
        pick = $urandom_range(99);
        if (pick < 35)
            w = tag_word(KIND_GEN, wide, id, strength_bit, 16'($urandom_range(16'hffff)));
        else if (pick < 75)
            w = check_word(wide, id, strength_bit, 16'h0);
        else if (pick < 90)
            w = check_word(wide, id, strength_bit, 16'h1 << $urandom_range(15));
        else
            w = tag_word(KIND_VAL, wide, id, strength_bit, 16'($urandom_range(16'hffff)));
        return w;
    endfunction

    task automatic queue_word(input t_item w);
        id_words_q.push_back(w);
        words_queued++;
    endtask

    // driver: one word held until taken, random gaps per phase
    always @(negedge i_clk) begin
        t_item w;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || s_taken) begin
            if (id_words_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                w = id_words_q.pop_front();
                i_s_tdata <= {7'b0, w.tag_in, w.strength, w.ident};
                i_s_tuser <= {w.wide, w.kind};
                i_s_tvalid <= 1'b1;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // monitor: predict on each taken word, check each delivered word
    always @(posedge i_clk) begin
        t_item       w;
        t_tag_result got;
        t_tag_result want;
        if (!i_rst_n) begin
            s_taken <= 1'b0;
        end else begin
            s_taken <= i_s_tvalid && o_s_tready;
            if (i_s_tvalid && o_s_tready) begin
                w = tag_word(i_s_tuser[0], i_s_tuser[1], i_s_tdata[63:0], i_s_tdata[64],
                             i_s_tdata[80:65]);
                tag_results_due.push_back(predict_tag_result(w));
                words_taken++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.tag_out = o_m_tdata[15:0];
                got.ok = o_m_tdata[16];
                got.ident_out = o_m_tdata[80:17];
                if (tag_results_due.size() == 0) begin
                    $display("%0t: unexpected word, got tag %h ok %b id %h",
                             $time, got.tag_out, got.ok, got.ident_out);
                    mismatches++;
                end else begin
                    want = tag_results_due.pop_front();
                    if (got.tag_out !== want.tag_out || got.ok !== want.ok ||
                            got.ident_out !== want.ident_out) begin
                        $display("%0t: mismatch, exp tag %h ok %b id %h, got tag %h ok %b id %h",
                                 $time, want.tag_out, want.ok, want.ident_out,
                                 got.tag_out, got.ok, got.ident_out);
                        mismatches++;
                    end
                end
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 4; ph++) begin
            @(posedge i_clk);
            case (ph)
                0: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 83;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 83;
                end
                default: begin
                    src_idle_pct = 10;
                    snk_stall_pct = 10;
                end
            endcase
            if (ph == 0) begin
                queue_word(tag_word(KIND_GEN, 1'b1, 64'h0, 1'b0, 16'h0));
                queue_word(tag_word(KIND_GEN, 1'b1, '1, 1'b1, 16'hffff));
                queue_word(tag_word(KIND_GEN, 1'b0, 64'h0, 1'b1, 16'h0));
                // upper half must be ignored in narrow mode
                queue_word(tag_word(KIND_GEN, 1'b0, '1, 1'b0, 16'hffff));
                queue_word(tag_word(KIND_GEN, 1'b0, 64'hffff_ffff_0000_0000, 1'b1, 16'h0));
                queue_word(check_word(1'b1, 64'h0, 1'b1, 16'h0));
                queue_word(check_word(1'b1, 64'h0, 1'b0, 16'h0));
                // shift drops the top bit
                queue_word(check_word(1'b1, '1, 1'b0, 16'h0));
                queue_word(check_word(1'b1, 64'h8000_0000_0000_0001, 1'b1, 16'h0));
                queue_word(check_word(1'b0, 64'h0000_0000_ffff_ffff, 1'b1, 16'h0));
                queue_word(check_word(1'b0, 64'h1234_5678_8000_0000, 1'b0, 16'h0));
                queue_word(check_word(1'b0, 64'h0, 1'b0, 16'h0));
                // one replaced bit flipped breaks parity agreement
                queue_word(check_word(1'b1, 64'h0123_4567_89ab_cdef, 1'b1, 16'h1 << W_POS_A));
                queue_word(check_word(1'b0, 64'hcafe_f00d, 1'b0, 16'h1 << N_POS_B));
                // kept bit flipped fails the hash compare
                queue_word(check_word(1'b1, 64'h0123_4567_89ab_cdef, 1'b0, 16'h0008));
                queue_word(check_word(1'b0, 64'hcafe_f00d, 1'b1, 16'h2000));
                // both replaced bits flipped pass with the other strength
                queue_word(check_word(1'b1, 64'hfeed_face_dead_beef, 1'b1,
                                      (16'h1 << W_POS_A) | (16'h1 << W_POS_B)));
                queue_word(check_word(1'b0, 64'h7fff_ffff, 1'b0,
                                      (16'h1 << N_POS_A) | (16'h1 << N_POS_B)));
                queue_word(tag_word(KIND_VAL, 1'b1, '1, 1'b1, 16'h0));
                queue_word(tag_word(KIND_VAL, 1'b1, 64'h0, 1'b0, 16'hffff));
                queue_word(tag_word(KIND_VAL, 1'b0, '1, 1'b1, 16'hffff));
                queue_word(tag_word(KIND_VAL, 1'b0, 64'h0, 1'b0, 16'h0));
            end
            repeat (RANDOM_WORDS_PER_PHASE) queue_word(random_word());
            // sender holds off until the pipe has drained
            while (words_taken != words_queued || tag_results_due.size() != 0)
                @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && tag_results_due.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
rtl/core/icv_pkg.sv
rtl/core/icv_hash_pipe.sv
rtl/core/id_check_tag_generate_validate_top.sv
bench/tb_id_check_tag_generate_validate_top.sv
